[rtl/nle_pkg.sv]
// Shared constants and types for the normalized Laplacian engine.
`default_nettype none

package nle_pkg;

  localparam int MAX_NODES = 64;
  localparam int SIM_W     = 16;
  localparam int IDX_W     = $clog2(MAX_NODES);
  localparam int CNT_W     = IDX_W + 1;
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int DEG_W     = SIM_W + IDX_W;
  localparam int PROD_W    = 2 * DEG_W;
  localparam int ROOT_W    = DEG_W;
  localparam int FRAC_W    = 15;
  localparam int NUM_W     = DEG_W + FRAC_W + 1;
  localparam int SUB_W     = ROOT_W + 3;
  localparam int ITER_W    = $clog2(NUM_W);
  localparam int OUT_W     = 16;
  localparam int IN_DATA_W = ((2 * IDX_W + SIM_W + 7) / 8) * 8;
  localparam int IN_USER_W = 1;
  localparam int OUT_USER_W = 3;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  // subtract-compare result
  typedef struct packed {
    logic             ge;
    logic [SUB_W-1:0] diff;
  } sub_res_t;

endpackage

`default_nettype wire

[rtl/nle_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module nle_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

[rtl/nle_sub_unit.sv]
// Shared subtract-and-compare unit used by the root and divide iterations.
`default_nettype none

module nle_sub_unit (
  input  wire logic [nle_pkg::SUB_W-1:0] a_i,
  input  wire logic [nle_pkg::SUB_W-1:0] b_i,
  output nle_pkg::sub_res_t              res_o
);
  import nle_pkg::*;

  logic [SUB_W:0] wide;

  // borrow bit clear means a >= b
  assign wide       = {1'b0, a_i} - {1'b0, b_i};
  assign res_o.ge   = ~wide[SUB_W];
  assign res_o.diff = wide[SUB_W-1:0];

endmodule

`default_nettype wire

[rtl/normalized_laplacian_engine.sv]
// Top level: similarity/degree stores and the read/write sequencer.
//
// Channel  Dir  Signals                        Contents (low bit up)
// s_axis   in   tvalid/tready/tdata/tuser      tdata: row[5:0] col[11:6] sim[27:12]; tuser: req
// m_axis   out  tvalid/tready/tdata/tuser      tdata: laplacian value; tuser: zd, sat, idx_err
// cfg      in   cfg_we_i/cfg_wdata_i           node_count
//
// Steps: a write request goes through accept, fetch and update. A diagonal read
// divides, an off-diagonal read takes a root first: both use the one shared
// subtractor, run 22 times for the integer square root of D_i*D_j and 38 times
// for the restoring division, one bit per cycle.
// Reset: a clearing pass zeroes all 4096 entries of the similarity RAM (and the degree
// RAM at its first 64 addresses); no request is taken meanwhile, config writes are.
// Stalls: a finished result sits in the output register; a new request is taken
// while it waits, but a later read holds in its last step until the register frees.
`default_nettype none

module normalized_laplacian_engine (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // request stream
  input  wire logic                             s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // [5:0] row_index, [11:6] col_index, [27:12] sim_value, [31:28] zero
  input  wire logic [nle_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  // [0] req_type
  input  wire logic [nle_pkg::IN_USER_W-1:0]    s_axis_tuser_i,
  // result stream
  output logic                                  m_axis_tvalid_o,
  input  wire logic                             m_axis_tready_i,
  // [15:0] laplacian_value
  output logic      [nle_pkg::OUT_W-1:0]        m_axis_tdata_o,
  // [0] zero_degree, [1] saturated, [2] index_error
  output logic      [nle_pkg::OUT_USER_W-1:0]   m_axis_tuser_o,
  // node_count register
  input  wire logic                             cfg_we_i,
  input  wire logic [nle_pkg::CNT_W-1:0]        cfg_wdata_i
);
  import nle_pkg::*;

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_FETCH = 4'd2;
  localparam logic [3:0] ST_LOAD  = 4'd3;
  localparam logic [3:0] ST_LOAD2 = 4'd4;
  localparam logic [3:0] ST_SQRT  = 4'd5;
  localparam logic [3:0] ST_PREP  = 4'd6;
  localparam logic [3:0] ST_DIV   = 4'd7;
  localparam logic [3:0] ST_DONE  = 4'd8;

  localparam logic [NUM_W-1:0] POS_MAX = NUM_W'(32767);
  localparam logic [NUM_W-1:0] NEG_MAG = NUM_W'(32768);

  logic [3:0]          state_q, state_d;
  logic [CNT_W-1:0]    nodes_q;
  logic [ADDR_W-1:0]   clr_q;
  logic [ITER_W-1:0]   iter_q, iter_d;

  // latched request
  logic [IDX_W-1:0]    row_q, col_q;
  logic [SIM_W-1:0]    sim_q;
  logic                read_q;
  logic                idxerr_q, idxerr_d;
  logic                zero_q, zero_d;

  // datapath
  logic [SIM_W-1:0]    s_q, s_d;
  logic [DEG_W-1:0]    di_q, di_d;
  logic [PROD_W-1:0]   prod_q, prod_d;
  logic [SUB_W-1:0]    rem_q, rem_d;
  logic [ROOT_W-1:0]   root_q, root_d;
  logic [NUM_W-1:0]    num_q, num_d;
  logic [ROOT_W-1:0]   div_q, div_d;

  // output register
  logic                out_valid_q;
  logic [OUT_W-1:0]    out_data_q;
  logic [OUT_USER_W-1:0] out_user_q;

  logic                in_acc;
  logic [IDX_W-1:0]    in_row, in_col;
  logic [SIM_W-1:0]    in_sim;
  logic                in_range;
  logic                diag;
  logic                out_free;
  logic                out_load;

  // RAM ports
  logic                sim_we;
  logic [ADDR_W-1:0]   sim_waddr;
  logic [SIM_W-1:0]    sim_wdata;
  logic [SIM_W-1:0]    sim_rdata;
  logic                deg_we;
  logic [IDX_W-1:0]    deg_waddr;
  logic [DEG_W-1:0]    deg_wdata;
  logic [IDX_W-1:0]    deg_raddr;
  logic [DEG_W-1:0]    deg_rdata;

  // shared unit
  logic [SUB_W-1:0]    sub_a, sub_b;
  sub_res_t            sub_res;

  logic [OUT_W-1:0]    res_value;
  logic                res_sat;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc   = s_axis_tvalid_i & s_axis_tready_o;
  assign in_row   = s_axis_tdata_i[IDX_W-1:0];
  assign in_col   = s_axis_tdata_i[2*IDX_W-1:IDX_W];
  assign in_sim   = s_axis_tdata_i[2*IDX_W+SIM_W-1:2*IDX_W];
  // indices never reach MAX_NODES, so node_count needs no clamp here
  assign in_range = (CNT_W'(in_row) < nodes_q) && (CNT_W'(in_col) < nodes_q);
  assign diag     = (row_q == col_q);
  assign out_free = ~out_valid_q | m_axis_tready_i;
  assign out_load = (state_q == ST_DONE) && out_free;

  // ---------------- stores ----------------
  always_comb begin
    if (state_q == ST_CLEAR) begin
      sim_we    = 1'b1;
      sim_waddr = clr_q;
      sim_wdata = '0;
      deg_we    = (clr_q[ADDR_W-1:IDX_W] == '0);
      deg_waddr = clr_q[IDX_W-1:0];
      deg_wdata = '0;
    end else begin
      sim_we    = (state_q == ST_LOAD) && (read_q == REQ_WRITE);
      sim_waddr = {row_q, col_q};
      sim_wdata = sim_q;
      deg_we    = sim_we;
      deg_waddr = row_q;
      // degree correction: drop old entry, add new one
      deg_wdata = deg_rdata - DEG_W'(sim_rdata) + DEG_W'(sim_q);
    end
  end

  // second degree read (column) goes out while the first is consumed
  assign deg_raddr = (state_q == ST_LOAD) ? col_q : row_q;

  nle_ram #(
    .DEPTH (MAX_NODES * MAX_NODES),
    .WIDTH (SIM_W)
  ) u_sim_ram (
    .clk_i   (clk_i),
    .we_i    (sim_we),
    .waddr_i (sim_waddr),
    .wdata_i (sim_wdata),
    .raddr_i ({row_q, col_q}),
    .rdata_o (sim_rdata)
  );

  nle_ram #(
    .DEPTH (MAX_NODES),
    .WIDTH (DEG_W)
  ) u_deg_ram (
    .clk_i   (clk_i),
    .we_i    (deg_we),
    .waddr_i (deg_waddr),
    .wdata_i (deg_wdata),
    .raddr_i (deg_raddr),
    .rdata_o (deg_rdata)
  );

  // ---------------- shared subtractor ----------------
  // root step: rem:next two product bits against {root,01}
  // divide step: rem:next numerator bit against divisor
  always_comb begin
    if (state_q == ST_SQRT) begin
      sub_a = {rem_q[SUB_W-3:0], prod_q[PROD_W-1:PROD_W-2]};
      sub_b = SUB_W'({root_q, 2'b01});
    end else begin
      sub_a = {rem_q[SUB_W-2:0], num_q[NUM_W-1]};
      sub_b = SUB_W'(div_q);
    end
  end

  nle_sub_unit u_sub (
    .a_i   (sub_a),
    .b_i   (sub_b),
    .res_o (sub_res)
  );

  // ---------------- sequencer ----------------
  always_comb begin
    state_d  = state_q;
    iter_d   = iter_q;
    idxerr_d = idxerr_q;
    zero_d   = zero_q;
    s_d      = s_q;
    di_d     = di_q;
    prod_d   = prod_q;
    rem_d    = rem_q;
    root_d   = root_q;
    num_d    = num_q;
    div_d    = div_q;

    case (state_q)
      ST_CLEAR: begin
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          idxerr_d = ~in_range;
          zero_d   = 1'b0;
          num_d    = '0;
          if (in_range) begin
            state_d = ST_FETCH;
          end else if (s_axis_tuser_i[0] == REQ_READ) begin
            state_d = ST_DONE;
          end
        end
      end
      ST_FETCH: begin
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        s_d  = sim_rdata;
        di_d = deg_rdata;
        if (read_q == REQ_WRITE) begin
          state_d = ST_IDLE;
        end else if (!diag) begin
          state_d = ST_LOAD2;
        end else if (deg_rdata == '0) begin
          zero_d  = 1'b1;
          state_d = ST_DONE;
        end else begin
          // ((D - S) << 15) + D/2 over D
          num_d   = NUM_W'({deg_rdata - DEG_W'(sim_rdata), FRAC_W'(0)})
                  + NUM_W'(deg_rdata >> 1);
          div_d   = deg_rdata;
          rem_d   = '0;
          iter_d  = '0;
          state_d = ST_DIV;
        end
      end
      ST_LOAD2: begin
        if (di_q == '0 || deg_rdata == '0) begin
          zero_d  = 1'b1;
          state_d = ST_DONE;
        end else begin
          prod_d  = di_q * deg_rdata;
          rem_d   = '0;
          root_d  = '0;
          iter_d  = '0;
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        rem_d  = sub_res.ge ? sub_res.diff : sub_a;
        root_d = {root_q[ROOT_W-2:0], sub_res.ge};
        prod_d = {prod_q[PROD_W-3:0], 2'b00};
        iter_d = iter_q + ITER_W'(1);
        if (iter_q == ITER_W'(ROOT_W - 1)) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        // (S << 15) + r/2 over r
        num_d   = NUM_W'({s_q, FRAC_W'(0)}) + NUM_W'(root_q >> 1);
        div_d   = root_q;
        rem_d   = '0;
        iter_d  = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        rem_d  = sub_res.ge ? sub_res.diff : sub_a;
        num_d  = {num_q[NUM_W-2:0], sub_res.ge};
        iter_d = iter_q + ITER_W'(1);
        if (iter_q == ITER_W'(NUM_W - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // ---------------- result shaping ----------------
  always_comb begin
    res_value = '0;
    res_sat   = 1'b0;
    if (!idxerr_q && !zero_q) begin
      if (diag) begin
        if (num_q > POS_MAX) begin
          res_value = OUT_W'(POS_MAX);
          res_sat   = 1'b1;
        end else begin
          res_value = num_q[OUT_W-1:0];
        end
      end else begin
        if (num_q > NEG_MAG) begin
          res_value = OUT_W'(NEG_MAG);
          res_sat   = 1'b1;
        end else begin
          res_value = ~num_q[OUT_W-1:0] + OUT_W'(1);
        end
      end
    end
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      nodes_q     <= CNT_W'(MAX_NODES);
      out_valid_q <= 1'b0;
      iter_q      <= '0;
    end else begin
      state_q <= state_d;
      iter_q  <= iter_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + ADDR_W'(1);
      end
      if (cfg_we_i) begin
        nodes_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      row_q  <= in_row;
      col_q  <= in_col;
      sim_q  <= in_sim;
      read_q <= s_axis_tuser_i[0];
    end
    idxerr_q <= idxerr_d;
    zero_q   <= zero_d;
    s_q      <= s_d;
    di_q     <= di_d;
    prod_q   <= prod_d;
    rem_q    <= rem_d;
    root_q   <= root_d;
    num_q    <= num_d;
    div_q    <= div_d;
    if (out_load) begin
      out_data_q <= res_value;
      out_user_q <= {idxerr_q, res_sat, zero_q};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

`ifndef SYNTHESIS
  // nothing comes out while the stores are being cleared
  a_no_out_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !m_axis_tvalid_o)
    else $error("result valid during clearing pass");

  // divisor is never zero once dividing
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (div_q != '0))
    else $error("division by zero degree or root");

  // diagonal quotient can reach at most one
  a_diag_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && diag && !zero_q && !idxerr_q) |-> (num_q <= NEG_MAG))
    else $error("diagonal quotient above one");

  // at most one status flag per result
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> $onehot0(m_axis_tuser_o))
    else $error("conflicting result flags");

  // root iteration count stays inside the root width
  a_sqrt_iter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SQRT) |-> (iter_q < ITER_W'(ROOT_W)))
    else $error("square root iteration overrun");
`endif

endmodule

`default_nettype wire
